FILE: hw/rtl/siphash24_keyed_hash_unit_assert.svh
// Assertion macros for the keyed hash unit; they use clk and rst_n of the asserting module.
`ifndef SIPHASH24_KEYED_HASH_UNIT_ASSERT_SVH
`define SIPHASH24_KEYED_HASH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SIP24_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SIP24_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIP24_ASSERT_SAME(lbl, ante, cons)
`define SIP24_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/sip24_pkg.sv
`timescale 1ns / 1ps

package sip24_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
    rotl = (x << s) | (x >> (64 - s));
  endfunction

  function automatic lanes_t sip_round(input lanes_t a);
    lanes_t b;
    b = a;
    b.v0 = b.v0 + b.v1;
    b.v1 = rotl(b.v1, 13) ^ b.v0;
    b.v0 = rotl(b.v0, 32);
    b.v2 = b.v2 + b.v3;
    b.v3 = rotl(b.v3, 16) ^ b.v2;
    b.v0 = b.v0 + b.v3;
    b.v3 = rotl(b.v3, 21) ^ b.v0;
    b.v2 = b.v2 + b.v1;
    b.v1 = rotl(b.v1, 17) ^ b.v2;
    b.v2 = rotl(b.v2, 32);
    sip_round = b;
  endfunction

endpackage

FILE: hw/rtl/siphash24_keyed_hash_unit.sv
`timescale 1ns / 1ps
// channel | direction | beat
// in_*    | in        | data_word, byte_count, last_word
// out_*   | out       | hash_value, one per message
// cfg_*   | in        | key_low / key_high write, no handshake
// One SipRound a cycle in a single round unit: the next beat is taken in the last round
// of a full word. A last beat keeps in_ready low through the length block (after the
// word's own rounds if it is full), the finalization rounds and the output load.
// Synchronous active-low reset; no clearing pass.
// in_ready drops while a word is in flight; a held result stalls only the final load.

`include "siphash24_keyed_hash_unit_assert.svh"

module siphash24_keyed_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MSG  = 5'b00010,
    S_BLK  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         rnd_r, rnd_nxt;
  logic               fresh_r, fresh_nxt;
  logic               fin_r, fin_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [63:0]        key_lo_r, key_hi_r;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        hash_r, hash_nxt;
  sip24_pkg::lanes_t  lanes_r, lanes_nxt;
  logic [63:0]        m_r, m_nxt;
  logic [63:0]        blk_r, blk_nxt;

  sip24_pkg::lanes_t  rl, msg_done, base, init;
  logic               acc, out_free, msg_end;
  logic [7:0]         len_base, len_new;
  logic [55:0]        tail_bytes;

  assign rl       = sip24_pkg::sip_round(lanes_r);
  assign msg_end  = (state_r == S_MSG) && (rnd_r == 2'd1);
  assign in_ready = (state_r == S_IDLE) || (msg_end && !fin_r);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

  always_comb begin
    msg_done    = rl;
    msg_done.v0 = rl.v0 ^ m_r;
    base = (state_r == S_IDLE) ? lanes_r : msg_done;
    if (fresh_r) begin
      init.v0 = key_lo_r ^ sip24_pkg::SIP_C0;
      init.v1 = key_hi_r ^ sip24_pkg::SIP_C1;
      init.v2 = key_lo_r ^ sip24_pkg::SIP_C2;
      init.v3 = key_hi_r ^ sip24_pkg::SIP_C3;
    end else begin
      init = base;
    end
    len_base = fresh_r ? 8'd0 : len_r;
    if (!in_last_word || in_byte_count[3]) begin
      len_new = len_base + 8'd8;
    end else begin
      len_new = len_base + {5'd0, in_byte_count[2:0]};
    end
    for (int i = 0; i < 7; i++) begin
      tail_bytes[8*i +: 8] = (3'(i) < in_byte_count[2:0]) ? in_data_word[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    fresh_nxt     = fresh_r;
    fin_nxt       = fin_r;
    len_nxt       = len_r;
    lanes_nxt     = lanes_r;
    m_nxt         = m_r;
    blk_nxt       = blk_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_MSG: begin
        lanes_nxt = rl;
        rnd_nxt   = rnd_r + 2'd1;
        if (msg_end) begin
          rnd_nxt = 2'd0;
          if (fin_r) begin
            lanes_nxt    = msg_done;
            lanes_nxt.v3 = msg_done.v3 ^ blk_r;
            m_nxt        = blk_r;
            fin_nxt      = 1'b0;
            state_nxt    = S_BLK;
          end else begin
            lanes_nxt = msg_done;
            state_nxt = S_IDLE;
          end
        end
      end
      S_BLK: begin
        lanes_nxt = rl;
        rnd_nxt   = rnd_r + 2'd1;
        if (rnd_r == 2'd1) begin
          lanes_nxt.v0 = rl.v0 ^ m_r;
          lanes_nxt.v2 = rl.v2 ^ sip24_pkg::SIP_FIN;
          rnd_nxt      = 2'd0;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        lanes_nxt = rl;
        rnd_nxt   = rnd_r + 2'd1;
        if (rnd_r == 2'd3) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          hash_nxt      = lanes_r.v0 ^ lanes_r.v1 ^ lanes_r.v2 ^ lanes_r.v3;
          out_valid_nxt = 1'b1;
          fresh_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: ;
    endcase

    if (acc) begin
      fresh_nxt = 1'b0;
      len_nxt   = len_new;
      rnd_nxt   = 2'd0;
      lanes_nxt = init;
      if (!in_last_word || in_byte_count[3]) begin
        lanes_nxt.v3 = init.v3 ^ in_data_word;
        m_nxt        = in_data_word;
        blk_nxt      = {len_new, 56'd0};
        fin_nxt      = in_last_word;
        state_nxt    = S_MSG;
      end else begin
        blk_nxt      = {len_new, tail_bytes};
        lanes_nxt.v3 = init.v3 ^ {len_new, tail_bytes};
        m_nxt        = {len_new, tail_bytes};
        fin_nxt      = 1'b0;
        state_nxt    = S_BLK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= 2'd0;
      fresh_r     <= 1'b1;
      fin_r       <= 1'b0;
      len_r       <= 8'd0;
      out_valid_r <= 1'b0;
      key_lo_r    <= 64'd0;
      key_hi_r    <= 64'd0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      fresh_r     <= fresh_nxt;
      fin_r       <= fin_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == sip24_pkg::REG_KEY_LOW) begin
        key_lo_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == sip24_pkg::REG_KEY_HIGH) begin
        key_hi_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    m_r     <= m_nxt;
    blk_r   <= blk_nxt;
    hash_r  <= hash_nxt;
  end

  `SIP24_ASSERT_NEXT(a_accept_busy, acc, state_r != S_IDLE)
  `SIP24_ASSERT_SAME(a_busy_not_fresh, state_r != S_IDLE, !fresh_r)
  `SIP24_ASSERT_NEXT(a_out_load, state_r == S_OUT && out_free, out_valid_r && fresh_r)
  `SIP24_ASSERT_SAME(a_fin_only_msg, fin_r, state_r == S_MSG)

endmodule

FILE: tb/sv/siphash24_keyed_hash_unit_tb.sv
`timescale 1ns / 1ps

class sip_tag_scoreboard;
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  logic [63:0] v0, v1, v2, v3;
  logic [7:0]  len_mod;
  int          len_full;
  bit          fresh;
  logic [63:0] tags_due[$];
  int          beats;
  int          tags_ok;
  int          mismatches;
  int          long_msgs;

  function new();
    key_lo     = '0;
    key_hi     = '0;
    v0         = '0;
    v1         = '0;
    v2         = '0;
    v3         = '0;
    len_mod    = '0;
    len_full   = 0;
    fresh      = 1'b1;
    beats      = 0;
    tags_ok    = 0;
    mismatches = 0;
    long_msgs  = 0;
  endfunction

  function void set_key(logic [63:0] lo, logic [63:0] hi);
    key_lo = lo;
    key_hi = hi;
  endfunction

  function logic [63:0] rotl64(logic [63:0] x, int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function void mix();
    v0 = v0 + v1;
    v1 = rotl64(v1, 13) ^ v0;
    v0 = rotl64(v0, 32);
    v2 = v2 + v3;
    v3 = rotl64(v3, 16) ^ v2;
    v0 = v0 + v3;
    v3 = rotl64(v3, 21) ^ v0;
    v2 = v2 + v1;
    v1 = rotl64(v1, 17) ^ v2;
    v2 = rotl64(v2, 32);
  endfunction

  function void absorb_word(logic [63:0] m);
    v3 = v3 ^ m;
    mix();
    mix();
    v0 = v0 ^ m;
  endfunction

  // key is sampled on the first beat of each message only
  function void note_beat(logic [63:0] word, logic [3:0] count, logic last);
    logic [63:0] block;
    int          tail;
    tail = 0;
    beats++;
    if (fresh) begin
      v0       = key_lo ^ sip24_pkg::SIP_C0;
      v1       = key_hi ^ sip24_pkg::SIP_C1;
      v2       = key_lo ^ sip24_pkg::SIP_C2;
      v3       = key_hi ^ sip24_pkg::SIP_C3;
      len_mod  = '0;
      len_full = 0;
      fresh    = 1'b0;
    end
    if (!last || count >= 4'd8) begin
      absorb_word(word);
      len_mod  = len_mod + 8'd8;
      len_full += 8;
    end else begin
      tail     = int'(count);
      len_mod  = len_mod + 8'(count);
      len_full += int'(count);
    end
    if (last) begin
      block = {len_mod, 56'd0};
      if (tail > 0)
        block = block | (word & ((64'd1 << (8 * tail)) - 64'd1));
      absorb_word(block);
      v2 = v2 ^ sip24_pkg::SIP_FIN;
      repeat (4) mix();
      tags_due.push_back(v0 ^ v1 ^ v2 ^ v3);
      if (len_full > 255)
        long_msgs++;
      fresh = 1'b1;
    end
  endfunction

  function void check_tag(logic [63:0] got);
    logic [63:0] want;
    if (tags_due.size() == 0) begin
      $display("%0t: unexpected hash, expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = tags_due.pop_front();
      if (got !== want) begin
        $display("%0t: hash mismatch, expected %h, actual %h", $time, want, got);
        mismatches++;
      end else begin
        tags_ok++;
      end
    end
  endfunction

  function int pending();
    return tags_due.size();
  endfunction

  function void flush_pending();
    while (tags_due.size() != 0) begin
      $display("%0t: hash missing, expected %h, actual none", $time, tags_due.pop_front());
      mismatches++;
    end
  endfunction
endclass

module siphash24_keyed_hash_unit_tb;
  localparam int LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hash_value;
  logic        cfg_we = 1'b0;
  logic        cfg_index = sip24_pkg::REG_KEY_LOW;
  logic [63:0] cfg_wdata = '0;

  sip_tag_scoreboard sb = new();
  bit          in_idle = 1'b1;
  bit          out_idle = 1'b1;
  bit          hold_req = 1'b0;
  int          key_sets = 0;
  int unsigned cycle_count = 0;

  siphash24_keyed_hash_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hash_value(out_hash_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(input logic [63:0] word, input logic [3:0] count,
                           input logic last);
    int gap;
    gap = in_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= word;
    in_byte_count <= count;
    in_last_word  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(word, count, last);
  endtask

  task automatic send_random_message();
    int         n_full;
    int         k;
    logic [3:0] cnt;
    if ($urandom_range(0, 9) == 0)
      n_full = $urandom_range(30, 40);
    else
      n_full = $urandom_range(0, 5);
    for (k = 0; k < n_full; k++) begin
      if ($urandom_range(0, 7) == 0)
        cnt = 4'($urandom_range(0, 15));
      else
        cnt = 4'd8;
      send_beat(rand_word(), cnt, 1'b0);
    end
    if ($urandom_range(0, 5) == 0)
      cnt = 4'($urandom_range(9, 15));
    else
      cnt = 4'($urandom_range(0, 8));
    send_beat(rand_word(), cnt, 1'b1);
  endtask

  // drop valid, wait for every tag, then let the core finish any open word
  task automatic settle();
    int spin;
    spin = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    sb.flush_pending();
    repeat (12) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= sip24_pkg::REG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= sip24_pkg::REG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_key(lo, hi);
    key_sets++;
  endtask

  initial begin : hash_sink
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = 300;
        hold_req = 1'b0;
      end else begin
        stall = out_idle ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_tag(out_hash_value);
    end
  end

  initial begin : stimulus
    int          phase;
    int          target;
    logic [63:0] lo;
    logic [63:0] hi;
    phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message under the reset key
    send_beat(64'h0, 4'd0, 1'b1);
    settle();
    load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_beat(64'h0, 4'd0, 1'b1);
    send_beat(64'h0706050403020100, 4'd8, 1'b1);
    send_beat('1, 4'd8, 1'b0);
    send_beat('1, 4'd3, 1'b1);
    send_beat(64'h0123456789abcdef, 4'd2, 1'b0);
    send_beat(64'hfedcba9876543210, 4'd15, 1'b1);
    send_beat(64'h0, 4'd8, 1'b0);
    send_beat(64'h8000000000000001, 4'd9, 1'b1);
    send_beat('1, 4'd7, 1'b1);
    send_beat(64'h0, 4'd1, 1'b1);
    settle();
    load_key('0, '0);
    send_beat('1, 4'd8, 1'b1);
    send_beat(rand_word(), 4'd5, 1'b1);
    // leave a message open across a key change
    send_beat(rand_word(), 4'd8, 1'b0);
    settle();
    load_key('1, '1);
    send_beat(rand_word(), 4'd4, 1'b1);
    send_beat(rand_word(), 4'd0, 1'b1);
    send_beat(rand_word(), 4'd6, 1'b1);
    settle();

    while (sb.beats < 1550) begin
      case (phase % 4)
        1: begin
          lo = '0;
          hi = '0;
        end
        2: begin
          lo = '1;
          hi = '1;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      load_key(lo, hi);
      in_idle  = 1'($urandom_range(0, 1));
      out_idle = 1'($urandom_range(0, 1));
      if (phase == 2) begin
        in_idle  = 1'b0;
        hold_req = 1'b1;
      end
      target = sb.beats + $urandom_range(20, 80);
      while (sb.beats < target) send_random_message();
      settle();
      phase++;
    end

    $display("Run covered %0d beats, %0d hashes checked, %0d key settings, %0d long messages.",
             sb.beats, sb.tags_ok, key_sets, sb.long_msgs);
    $display("Included empty and wrapped lengths, odd byte counts and a key change mid-message.");
    if (sb.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sip24_pkg.sv
hw/rtl/siphash24_keyed_hash_unit.sv
tb/sv/siphash24_keyed_hash_unit_tb.sv
